// File: src/bsce_pkg.sv
// bsce_pkg: shared types and constants for the B-spline curve evaluator.
// Used by bsce_ctrl, bsce_datapath and bspline_curve_evaluator_core.
package bsce_pkg;

    localparam int CTR_W      = 3;
    localparam int HEIGHT_W   = 16;
    localparam int POS_W      = 16;
    localparam int INDEX_W    = 6;
    localparam int COUNT_W    = 7;
    localparam int OUT_W      = 24;
    localparam int BASIS_W    = 31;
    localparam int BASIS_ONE_BIT = 30;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd4;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic             wr;
        logic             start;
        logic             span;
        logic             init;
        logic             load;
        logic             mul;
        logic             div_init;
        logic             div_step;
        logic             acc;
        logic             store;
        logic             rd;
        logic             mac;
        logic             out;
        logic             side;
        logic [CTR_W-1:0] p;
        logic [CTR_W-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic guard;
        logic div_last;
    } t_status;

endpackage

// File: src/bsce_ram.sv
// bsce_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bsce_ctrl.sv
// bsce_ctrl: sequencer for load and evaluate items; walks the basis triangle.
// Depends on bsce_pkg for command and status types.
module bsce_ctrl #(
    parameter int SPLINE_DEGREE = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_mode,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  bsce_pkg::t_status i_status,
    output bsce_pkg::t_cmd    o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SPAN  = 11'b00000000010,
        S_INIT  = 11'b00000000100,
        S_LOAD  = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_DIVI  = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_ACC   = 11'b00010000000,
        S_STORE = 11'b00100000000,
        S_RD    = 11'b01000000000,
        S_MAC   = 11'b10000000000
    } t_state;

    localparam logic [bsce_pkg::CTR_W-1:0] DEG = bsce_pkg::CTR_W'(SPLINE_DEGREE);

    t_state                      r_state, n_state;
    logic [bsce_pkg::CTR_W-1:0]  r_p, n_p, r_k, n_k;
    logic                        r_side, n_side;
    logic                        r_ovalid, n_ovalid;
    logic                        r_fin, n_fin;
    logic                        accept;

    assign o_in_ready  = (r_state == S_IDLE) && !r_fin;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_k      = r_k;
        n_side   = r_side;
        n_fin    = r_fin;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        o_cmd.p    = r_p;
        o_cmd.k    = r_k;
        o_cmd.side = r_side;
        case (r_state)
            S_IDLE: begin
                if (r_fin) begin
                    if (!r_ovalid || i_out_ready) begin
                        o_cmd.out = 1'b1;
                        n_ovalid  = 1'b1;
                        n_fin     = 1'b0;
                    end
                end else if (accept) begin
                    if (i_in_mode == bsce_pkg::MODE_LOAD) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SPAN;
                    end
                end
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = S_INIT;
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_p        = bsce_pkg::CTR_W'(1);
                n_k        = DEG - bsce_pkg::CTR_W'(1);
                n_side     = 1'b0;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = i_status.guard ? S_MUL : S_ACC;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    n_side  = 1'b0;
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (r_k == DEG) begin
                    if (r_p == DEG) begin
                        n_k     = '0;
                        n_state = S_RD;
                    end else begin
                        n_p     = r_p + bsce_pkg::CTR_W'(1);
                        n_k     = DEG - r_p - bsce_pkg::CTR_W'(1);
                        n_state = S_LOAD;
                    end
                end else begin
                    n_k     = r_k + bsce_pkg::CTR_W'(1);
                    n_state = S_LOAD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (r_k == DEG) begin
                    n_fin   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + bsce_pkg::CTR_W'(1);
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p      <= '0;
            r_k      <= '0;
            r_side   <= 1'b0;
            r_ovalid <= 1'b0;
            r_fin    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p      <= n_p;
            r_k      <= n_k;
            r_side   <= n_side;
            r_ovalid <= n_ovalid;
            r_fin    <= n_fin;
        end
    end

endmodule

// File: src/bsce_datapath.sv
// bsce_datapath: knot math, basis triangle registers, shared divider, height MAC.
// Depends on bsce_pkg and bsce_ram.
module bsce_datapath #(
    parameter int SPLINE_DEGREE = 3,
    parameter int MAX_POINTS    = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bsce_pkg::COUNT_W-1:0]        i_cfg_wdata,
    input  logic [bsce_pkg::INDEX_W-1:0]        i_index,
    input  logic signed [bsce_pkg::HEIGHT_W-1:0] i_value,
    input  logic [bsce_pkg::POS_W-1:0]          i_pos,
    input  bsce_pkg::t_cmd                      i_cmd,
    output bsce_pkg::t_status                   o_status,
    output logic signed [bsce_pkg::OUT_W-1:0]   o_result
);

    localparam int D   = SPLINE_DEGREE;
    localparam int NW  = $clog2(MAX_POINTS + 1);
    localparam int MW  = NW + 1;
    localparam int SW  = bsce_pkg::POS_W + MW;
    localparam int AW  = $clog2(MAX_POINTS);
    localparam int KW  = $clog2(D + 1);
    localparam int DW  = 16 + $clog2(D + 1);
    localparam int BW  = bsce_pkg::BASIS_W;
    localparam int PW  = DW + BW;
    localparam int XW  = PW - 16;
    localparam int VW  = $clog2(D + 1);
    localparam int CW  = $clog2(XW + 1);
    localparam int ACW = bsce_pkg::HEIGHT_W + BW + 1 + $clog2(D + 2);
    localparam int MPW = bsce_pkg::HEIGHT_W + BW + 1;

    function automatic int knot_k(int j, int n, int m);
        int r;
        if (j < D) begin
            r = 0;
        end else if (j <= n) begin
            r = j - D + 1;
        end else begin
            r = m;
        end
        return r;
    endfunction

    logic [bsce_pkg::COUNT_W-1:0] r_point_count;
    logic [bsce_pkg::POS_W-1:0]   r_pos;
    logic [SW-1:0]                r_s;
    logic [BW-1:0]                r_b [D+1];
    logic [DW-1:0]                r_dist;
    logic [VW-1:0]                r_dv;
    logic                         r_guard;
    logic [BW-1:0]                r_bop;
    logic [PW-1:0]                r_prod;
    logic [XW-1:0]                r_quo;
    logic [VW-1:0]                r_rem;
    logic [CW-1:0]                r_cnt;
    logic [BW:0]                  r_sum;
    logic signed [ACW-1:0]        r_acc;
    logic                         r_rd_ok;
    logic signed [bsce_pkg::OUT_W-1:0] r_out;

    logic [NW-1:0]                n_cnt_pts;
    logic [MW-1:0]                m_val;
    logic [MW-1:0]                q_val;
    logic [KW-1:0]                k_idx;
    logic [KW-1:0]                b_idx;
    logic                         b_zero;
    logic [DW-1:0]                t_dist;
    logic [VW-1:0]                t_dv;
    logic                         t_guard;
    logic [AW-1:0]                rd_addr;
    logic                         rd_ok;
    logic                         wr_en;
    logic [bsce_pkg::HEIGHT_W-1:0] ram_dout;
    logic [VW:0]                  div_tmp;
    logic                         div_bit;
    logic signed [ACW-1:0]        rnd;
    logic signed [MPW-1:0]        mac_prod;

    always_comb begin
        int pc;
        pc = int'(r_point_count);
        if (pc < D) pc = D;
        if (pc > MAX_POINTS) pc = MAX_POINTS;
        n_cnt_pts = NW'(pc);
        m_val     = MW'(pc - D + 2);
    end

    assign q_val = r_s[SW-1:bsce_pkg::POS_W];
    assign k_idx = i_cmd.k[KW-1:0];

    always_comb begin
        int j, pp, lo, hi, dlen, sc;
        j  = int'(q_val) + int'(i_cmd.k) - 1;
        pp = int'(i_cmd.p);
        sc = int'(r_s);
        b_idx  = k_idx;
        b_zero = 1'b0;
        if (!i_cmd.side) begin
            lo   = knot_k(j, int'(n_cnt_pts), int'(m_val));
            hi   = knot_k(j + pp, int'(n_cnt_pts), int'(m_val));
            dlen = sc - lo * 65536;
        end else begin
            lo   = knot_k(j + 1, int'(n_cnt_pts), int'(m_val));
            hi   = knot_k(j + pp + 1, int'(n_cnt_pts), int'(m_val));
            dlen = hi * 65536 - sc;
            if (int'(i_cmd.k) >= D) begin
                b_zero = 1'b1;
            end else begin
                b_idx = k_idx + KW'(1);
            end
        end
        t_dist  = DW'(dlen);
        t_dv    = VW'(hi - lo);
        t_guard = (hi != lo) && (j >= 0) && !b_zero && (r_b[b_idx] != '0);
        rd_ok   = (j >= 0) && (j < int'(n_cnt_pts));
        rd_addr = AW'(j);
    end

    assign o_status = '{guard: t_guard, div_last: (r_cnt == CW'(1))};

    assign div_tmp = {r_rem, r_quo[XW-1]};
    assign div_bit = (div_tmp >= {1'b0, r_dv});

    assign wr_en = i_cmd.wr && (32'(i_index) < MAX_POINTS);

    assign mac_prod = MPW'($signed(ram_dout)) * MPW'($signed({1'b0, r_b[k_idx]}));

    bsce_ram #(
        .WIDTH(bsce_pkg::HEIGHT_W),
        .DEPTH(MAX_POINTS)
    ) u_heights (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_index)),
        .i_wdata (i_value),
        .i_raddr (rd_addr),
        .o_rdata (ram_dout)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= bsce_pkg::COUNT_RESET;
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos <= i_pos;
        end
        if (i_cmd.span) begin
            r_s <= SW'(r_pos) * SW'(m_val);
        end
        if (i_cmd.init) begin
            for (int i = 0; i < D; i++) begin
                r_b[i] <= '0;
            end
            r_b[D] <= BW'(1) << bsce_pkg::BASIS_ONE_BIT;
            r_sum  <= '0;
            r_acc  <= '0;
        end
        if (i_cmd.load) begin
            r_dist  <= t_dist;
            r_dv    <= t_dv;
            r_guard <= t_guard;
            r_bop   <= r_b[b_idx];
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_dist) * PW'(r_bop);
        end
        if (i_cmd.div_init) begin
            r_quo <= r_prod[PW-1:16];
            r_rem <= '0;
            r_cnt <= CW'(XW);
        end
        if (i_cmd.div_step) begin
            r_rem <= div_bit ? VW'(div_tmp - {1'b0, r_dv}) : div_tmp[VW-1:0];
            r_quo <= {r_quo[XW-2:0], div_bit};
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.acc && r_guard) begin
            r_sum <= r_sum + (BW+1)'(r_quo[BW-1:0]);
        end
        if (i_cmd.acc) begin
            r_guard <= 1'b0;
        end
        if (i_cmd.store) begin
            r_b[k_idx] <= r_sum[BW-1:0];
            r_sum      <= '0;
        end
        if (i_cmd.rd) begin
            r_rd_ok <= rd_ok;
        end
        if (i_cmd.mac && r_rd_ok) begin
            r_acc <= r_acc + ACW'(mac_prod);
        end
        if (i_cmd.out) begin
            r_out <= (rnd > $signed({{(ACW-24){1'b0}}, 24'h7FFFFF})) ? 24'sh7FFFFF :
                     (rnd < $signed({{(ACW-24){1'b1}}, 24'h800000})) ? 24'sh800000 :
                     rnd[bsce_pkg::OUT_W-1:0];
        end
    end

    assign rnd      = (r_acc + (ACW'(1) << 21)) >>> 22;
    assign o_result = r_out;

endmodule

// File: src/bspline_curve_evaluator_core.sv
// A load item is written to the height RAM in the cycle it is taken. An evaluate item
// (degree 3) runs setup, then up to 12 nonzero basis terms through the 33-step shared
// divider and 6 zero terms that skip it, with 9 stores, then height accumulation and output.
// Throughput: one evaluate item at a time; the next item is taken the cycle after the result
// register loads. Reset (i_rst_n, synchronous, active low) clears control, point_count = 4.
module bspline_curve_evaluator_core #(
    parameter int SPLINE_DEGREE = 3,
    parameter int MAX_POINTS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,      // point_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,     // point_index[5:0], point_value[21:6],
                                          // eval_position[37:22], zero pad
    input  logic [0:0]  s_axis_tuser,     // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata      // curve_value
);

    bsce_pkg::t_cmd    cmd;
    bsce_pkg::t_status status;
    logic signed [bsce_pkg::OUT_W-1:0] result;

    bsce_ctrl #(
        .SPLINE_DEGREE(SPLINE_DEGREE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_mode   (s_axis_tuser[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bsce_datapath #(
        .SPLINE_DEGREE(SPLINE_DEGREE),
        .MAX_POINTS   (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_index     (s_axis_tdata[5:0]),
        .i_value     (s_axis_tdata[21:6]),
        .i_pos       (s_axis_tdata[37:22]),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_result    (result)
    );

    assign m_axis_tdata = result;

endmodule
